[hdl/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// ppc_pkg
// Types and constants shared by the perspective point projection core.
// ----------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

  typedef enum logic [2:0] {
    REG_CAMERA_X     = 3'd0,
    REG_CAMERA_Y     = 3'd1,
    REG_CAMERA_Z     = 3'd2,
    REG_ANGLE_FIRST  = 3'd3,
    REG_ANGLE_SECOND = 3'd4,
    REG_ANGLE_THIRD  = 3'd5,
    REG_FOCAL_LENGTH = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [15:0] a0;
    logic [15:0] a1;
    logic [15:0] a2;
  } angles_t;

  typedef struct packed {
    logic signed [17:0] s0;
    logic signed [17:0] s1;
    logic signed [17:0] s2;
    logic signed [17:0] c0;
    logic signed [17:0] c1;
    logic signed [17:0] c2;
  } trig_t;

  localparam logic [15:0]        QUARTER_TURN = 16'h4000;
  localparam logic [15:0]        FOCAL_RESET  = 16'd12800;
  localparam logic signed [17:0] TRIG_ONE     = 18'sd65536;
  localparam logic [2:0]         TRIG_LAST    = 3'd5;
  localparam trig_t TRIG_RESET = '{s0: '0, s1: '0, s2: '0,
                                   c0: TRIG_ONE, c1: TRIG_ONE, c2: TRIG_ONE};

  // focal * 35.6 in Q22.8 = focal * 9113 + round(focal * 0.6)
  localparam int unsigned E_INT_MUL    = 9113;
  localparam int unsigned E_FRAC_MUL   = 6;
  localparam int unsigned E_FRAC_ROUND = 5;
  localparam int unsigned E_RECIP_10   = 419431;
  localparam int unsigned E_RECIP_SH   = 22;

endpackage

`default_nettype wire

[hdl/ppc_if.sv]
// ----------------------------------------------------------------------------
// ppc_if
// Valid/ready channels of the projection core: world points in, screen out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppc_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

interface ppc_screen_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth;
  logic               zero_depth;

  modport source (output valid, output screen_x, output screen_y, output depth,
                  output zero_depth, input ready);
  modport sink   (input valid, input screen_x, input screen_y, input depth,
                  input zero_depth, output ready);
endinterface

`default_nettype wire

[hdl/ppc_trig.sv]
// ----------------------------------------------------------------------------
// ppc_trig
// Sine/cosine terms of the three camera angles from a quarter-wave table.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_trig import ppc_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire     clk,
  input  wire     rst_n,
  input  logic    start,
  input  angles_t angles,
  output trig_t   trig,
  output logic    busy
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH);

  typedef logic [16:0] rom_t [SINE_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t   t;
    longint x;
    longint x2;
    longint term;
    longint sum;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x    = (64'sd1686629713 * longint'(i)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >>> 30) / 6;   sum = sum - term;
      term = ((term * x2) >>> 30) / 20;  sum = sum + term;
      term = ((term * x2) >>> 30) / 42;  sum = sum - term;
      term = ((term * x2) >>> 30) / 72;  sum = sum + term;
      term = ((term * x2) >>> 30) / 110; sum = sum - term;
      term = ((term * x2) >>> 30) / 156; sum = sum + term;
      term = ((term * x2) >>> 30) / 210; sum = sum - term;
      term = ((term * x2) >>> 30) / 272; sum = sum + term;
      if (sum < 0) begin
        sum = 0;
      end
      t[i] = 17'((sum + 8192) >>> 14);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic          run_r;
  logic [2:0]    step_r;
  logic          wr_r;
  logic [2:0]    wr_sel_r;
  logic          wr_one_r;
  logic          wr_neg_r;
  logic [16:0]   rom_q_r;
  trig_t         trig_r;

  logic [15:0]   ang;
  logic [14:0]   lut_phase;
  logic [IW+14:0] idx_prod;
  logic [IW-1:0] idx;
  logic [16:0]   wr_mag;
  logic signed [17:0] wr_val;

  always_comb begin
    case (step_r)
      3'd0:    ang = angles.a0;
      3'd1:    ang = angles.a1;
      3'd2:    ang = angles.a2;
      3'd3:    ang = angles.a0 + QUARTER_TURN;
      3'd4:    ang = angles.a1 + QUARTER_TURN;
      3'd5:    ang = angles.a2 + QUARTER_TURN;
      default: ang = angles.a0;
    endcase
    lut_phase = ang[14] ? (15'(QUARTER_TURN) - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    idx_prod  = (IW+15)'(lut_phase[13:0]) * (IW+15)'(SINE_TABLE_DEPTH);
    idx       = idx_prod[IW+13:14];
    wr_mag    = wr_one_r ? 17'h10000 : rom_q_r;
    wr_val    = wr_neg_r ? -$signed({1'b0, wr_mag}) : $signed({1'b0, wr_mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
      wr_r   <= 1'b0;
      trig_r <= TRIG_RESET;
    end else begin
      wr_r <= run_r;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == TRIG_LAST) begin
          run_r <= 1'b0;
        end
      end
      if (wr_r) begin
        case (wr_sel_r)
          3'd0:    trig_r.s0 <= wr_val;
          3'd1:    trig_r.s1 <= wr_val;
          3'd2:    trig_r.s2 <= wr_val;
          3'd3:    trig_r.c0 <= wr_val;
          3'd4:    trig_r.c1 <= wr_val;
          3'd5:    trig_r.c2 <= wr_val;
          default: trig_r.s0 <= trig_r.s0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r  <= SINE_ROM[idx];
    wr_sel_r <= step_r;
    wr_one_r <= lut_phase[14];
    wr_neg_r <= ang[15];
  end

  assign trig = trig_r;
  assign busy = start || run_r || wr_r;

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> run_r && step_r == 3'd0)
    else $error("table refresh did not restart");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    run_r && !start && step_r == TRIG_LAST |=> !run_r && wr_r)
    else $error("table refresh did not finish after the last term");

endmodule

`default_nettype wire

[hdl/perspective_point_projection_core.sv]
// ----------------------------------------------------------------------------
// perspective_point_projection_core
// Projects world points through a configured camera to screen coordinates.
// ----------------------------------------------------------------------------
//  port        | dir | handshake     | payload
//  in_point    | in  | valid/ready   | point_x, point_y, point_z
//  out_result  | out | valid/ready   | screen_x, screen_y, depth, zero_depth
//  cfg_*       | in  | cfg_we only   | cfg_index, cfg_data
//
//  One request per cycle unless out_result or a refresh stalls; rotation,
//  scaling multiply, then a 32-step long division, one quotient bit per stage.
//  An angle write refreshes the sine table terms; in_point.ready
//  is low during that refresh.
//  Synchronous active-low reset clears valid bits, configuration registers and trig terms.
//  Stalls collapse bubbles: each stage advances when it is empty or its
//  successor advances.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_point_projection_core import ppc_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire          clk,
  input  wire          rst_n,
  ppc_point_if.sink    in_point,
  ppc_screen_if.source out_result,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int NS        = 42;
  localparam int DIV_BASE  = 8;
  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
  } lane_t;

  typedef struct packed {
    logic [31:0]        den;
    logic               neg_x;
    logic               neg_y;
    logic               ovf_x;
    logic               ovf_y;
    logic               zero;
    logic signed [31:0] depth;
  } dcom_t;

  function automatic logic signed [39:0] rnd16(logic signed [55:0] v);
    logic signed [55:0] t;
    t = v + 56'sd32768;
    return t[55:16];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic lane_t div_step(lane_t l, logic [31:0] den);
    logic [32:0] cand;
    logic        ge;
    lane_t       r;
    cand  = {l.rem, l.low[31]};
    ge    = cand >= {1'b0, den};
    r.rem = ge ? 32'(cand - {1'b0, den}) : cand[31:0];
    r.low = {l.low[30:0], 1'b0};
    r.quo = {l.quo[30:0], ge};
    return r;
  endfunction

  function automatic logic signed [31:0] sat_quo(logic [31:0] q, logic neg, logic ovf);
    if (neg) begin
      if (ovf || q > 32'h80000000) begin
        return 32'sh80000000;
      end
      return -$signed(q);
    end
    if (ovf || q[31]) begin
      return 32'sh7fffffff;
    end
    return $signed(q);
  endfunction

  // configuration
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  angles_t            angles_r;
  logic [15:0]        focal_r;
  logic [29:0]        e_r;
  logic               angle_wr;
  trig_t              trig;
  logic               trig_busy;

  assign angle_wr = cfg_we && (cfg_index inside {REG_ANGLE_FIRST, REG_ANGLE_SECOND,
                                                 REG_ANGLE_THIRD});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r  <= '0;
      cam_y_r  <= '0;
      cam_z_r  <= '0;
      angles_r <= '0;
      focal_r  <= FOCAL_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_CAMERA_X:     cam_x_r     <= cfg_data;
        REG_CAMERA_Y:     cam_y_r     <= cfg_data;
        REG_CAMERA_Z:     cam_z_r     <= cfg_data;
        REG_ANGLE_FIRST:  angles_r.a0 <= cfg_data[15:0];
        REG_ANGLE_SECOND: angles_r.a1 <= cfg_data[15:0];
        REG_ANGLE_THIRD:  angles_r.a2 <= cfg_data[15:0];
        REG_FOCAL_LENGTH: focal_r     <= cfg_data[15:0];
        default:          focal_r     <= focal_r;
      endcase
    end
  end

  logic [18:0] e_frac_num;
  logic [40:0] e_frac_prod;

  always_comb begin
    e_frac_num  = 19'(focal_r) * 19'(E_FRAC_MUL) + 19'(E_FRAC_ROUND);
    e_frac_prod = 41'(e_frac_num) * 41'(E_RECIP_10);
  end

  always_ff @(posedge clk) begin
    e_r <= 30'(focal_r) * 30'(E_INT_MUL) + 30'(e_frac_prod[40:E_RECIP_SH]);
  end

  ppc_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (angle_wr),
    .angles (angles_r),
    .trig   (trig),
    .busy   (trig_busy)
  );

  // pipeline control
  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;
  logic          in_fire;

  assign adv[NS-1] = !vld_r[NS-1] || out_result.ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = !vld_r[k] || adv[k+1];
  end

  assign in_point.ready = adv[0] && !trig_busy;
  assign in_fire        = in_point.valid && in_point.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_fire;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // datapath
  logic signed [32:0] dx_r, dy_r, dz_r, dz1_r, dz2_r;
  logic signed [50:0] p_sy_r, p_cx_r, p_cy_r, p_sx_r;
  logic signed [34:0] a_r, b_r, b3_r, b4_r;
  logic signed [50:0] q_cz_r, q_sz_r;
  logic signed [52:0] q_sa_r, q_ca_r;
  logic signed [35:0] c_r;
  logic signed [31:0] d0_4_r, d0_5_r, d0_6_r, d1_6_r, d2_6_r, d2_7_r;
  logic signed [53:0] r_sc_r, r_cc_r;
  logic signed [52:0] r_cb_r, r_sb_r;
  logic signed [62:0] nx_r, ny_r;
  logic               zero_7_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx_r <= 33'(in_point.point_x) - 33'(cam_x_r);
      dy_r <= 33'(in_point.point_y) - 33'(cam_y_r);
      dz_r <= 33'(in_point.point_z) - 33'(cam_z_r);
    end
    if (adv[1]) begin
      p_sy_r <= 51'(trig.s2) * 51'(dy_r);
      p_cx_r <= 51'(trig.c2) * 51'(dx_r);
      p_cy_r <= 51'(trig.c2) * 51'(dy_r);
      p_sx_r <= 51'(trig.s2) * 51'(dx_r);
      dz1_r  <= dz_r;
    end
    if (adv[2]) begin
      a_r   <= 35'(rnd16(56'(p_sy_r) + 56'(p_cx_r)));
      b_r   <= 35'(rnd16(56'(p_cy_r) - 56'(p_sx_r)));
      dz2_r <= dz1_r;
    end
    if (adv[3]) begin
      q_cz_r <= 51'(trig.c1) * 51'(dz2_r);
      q_sa_r <= 53'(trig.s1) * 53'(a_r);
      q_ca_r <= 53'(trig.c1) * 53'(a_r);
      q_sz_r <= 51'(trig.s1) * 51'(dz2_r);
      b3_r   <= b_r;
    end
    if (adv[4]) begin
      c_r    <= 36'(rnd16(56'(q_cz_r) + 56'(q_sa_r)));
      d0_4_r <= sat32(rnd16(56'(q_ca_r) - 56'(q_sz_r)));
      b4_r   <= b3_r;
    end
    if (adv[5]) begin
      r_sc_r <= 54'(trig.s0) * 54'(c_r);
      r_cb_r <= 53'(trig.c0) * 53'(b4_r);
      r_cc_r <= 54'(trig.c0) * 54'(c_r);
      r_sb_r <= 53'(trig.s0) * 53'(b4_r);
      d0_5_r <= d0_4_r;
    end
    if (adv[6]) begin
      d1_6_r <= sat32(rnd16(56'(r_sc_r) + 56'(r_cb_r)));
      d2_6_r <= sat32(rnd16(56'(r_cc_r) - 56'(r_sb_r)));
      d0_6_r <= d0_5_r;
    end
    if (adv[7]) begin
      nx_r     <= 63'($signed({1'b0, e_r})) * 63'(d0_6_r);
      ny_r     <= 63'($signed({1'b0, e_r})) * 63'(d1_6_r);
      d2_7_r   <= d2_6_r;
      zero_7_r <= d2_6_r == 32'sd0;
    end
  end

  // long division, one quotient bit per stage
  lane_t lx_r [DIV_STEPS+1];
  lane_t ly_r [DIV_STEPS+1];
  dcom_t com_r [DIV_STEPS+1];

  logic [62:0] mag_x, mag_y;
  logic [31:0] den;

  always_comb begin
    mag_x = nx_r[62] ? 63'(-nx_r) : 63'(nx_r);
    mag_y = ny_r[62] ? 63'(-ny_r) : 63'(ny_r);
    den   = d2_7_r[31] ? 32'(-d2_7_r) : 32'(d2_7_r);
  end

  always_ff @(posedge clk) begin
    if (adv[DIV_BASE]) begin
      lx_r[0]        <= '{rem: {2'b00, mag_x[61:32]}, low: mag_x[31:0], quo: '0};
      ly_r[0]        <= '{rem: {2'b00, mag_y[61:32]}, low: mag_y[31:0], quo: '0};
      com_r[0].den   <= den;
      com_r[0].neg_x <= nx_r[62] ^ d2_7_r[31];
      com_r[0].neg_y <= ny_r[62] ^ d2_7_r[31];
      com_r[0].ovf_x <= {2'b00, mag_x[61:32]} >= den;
      com_r[0].ovf_y <= {2'b00, mag_y[61:32]} >= den;
      com_r[0].zero  <= zero_7_r;
      com_r[0].depth <= d2_7_r;
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv[DIV_BASE+j]) begin
        lx_r[j]  <= div_step(lx_r[j-1], com_r[j-1].den);
        ly_r[j]  <= div_step(ly_r[j-1], com_r[j-1].den);
        com_r[j] <= com_r[j-1];
      end
    end
  end

  // output register
  logic signed [31:0] out_sx_r, out_sy_r, out_depth_r;
  logic               out_zero_r;

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      if (com_r[DIV_STEPS].zero) begin
        out_sx_r    <= '0;
        out_sy_r    <= '0;
        out_depth_r <= '0;
        out_zero_r  <= 1'b1;
      end else begin
        out_sx_r    <= sat_quo(lx_r[DIV_STEPS].quo, com_r[DIV_STEPS].neg_x,
                               com_r[DIV_STEPS].ovf_x);
        out_sy_r    <= sat_quo(ly_r[DIV_STEPS].quo, com_r[DIV_STEPS].neg_y,
                               com_r[DIV_STEPS].ovf_y);
        out_depth_r <= com_r[DIV_STEPS].depth;
        out_zero_r  <= 1'b0;
      end
    end
  end

  assign out_result.valid      = vld_r[NS-1];
  assign out_result.screen_x   = out_sx_r;
  assign out_result.screen_y   = out_sy_r;
  assign out_result.depth      = out_depth_r;
  assign out_result.zero_depth = out_zero_r;

  a_no_take_in_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    trig_busy |-> !in_point.ready)
    else $error("request taken during trig refresh");

  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_result.valid && out_result.zero_depth |->
      out_result.screen_x == 32'sd0 && out_result.screen_y == 32'sd0 &&
      out_result.depth == 32'sd0)
    else $error("zero depth result not cleared");

  a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_result.valid && !out_result.zero_depth |-> out_result.depth != 32'sd0)
    else $error("zero depth without flag");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_result.valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
